>>> hw/rtl/i2cbe_pkg.sv
// Shared types and constants of the I2C master bit engine.
package i2cbe_pkg;

   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_STOP  = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;
   localparam logic [2:0] OP_ACK   = 3'd5;
   localparam logic [2:0] OP_NACK  = 3'd6;

   localparam int unsigned CSR_DATA_W = 16;
   localparam logic CSR_PHASE_TICKS    = 1'b0;
   localparam logic CSR_ACK_POLL_LIMIT = 1'b1;

   localparam logic [15:0] PHASE_TICKS_RESET    = 16'd50;
   localparam logic [7:0]  ACK_POLL_LIMIT_RESET = 8'd50;

   typedef struct packed {
      logic       is_cmd;
      logic [2:0] op;
      logic [7:0] data_byte;
      logic       sda_pin;
   } item_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_drive_enable;
      logic       sda_drive_level;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       ack_seen;
   } rsp_type;

endpackage

>>> hw/rtl/i2cbe_fifo.sv
// Small register queue used between the front, the engine and the result port.
module i2cbe_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/i2cbe_front.sv
// Front end: accepts ticks, classifies the operation code and queues the item.
module i2cbe_front #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [2:0]          req_operation,
   input  logic [7:0]          req_data_byte,
   input  logic                req_sda_pin,
   output logic                item_valid,
   output i2cbe_pkg::item_type item,
   input  logic                item_pop
);

   i2cbe_pkg::item_type class_item;
   logic                item_empty;

   always_comb begin
      class_item.data_byte = req_data_byte;
      class_item.sda_pin   = req_sda_pin;
      if (req_operation inside {[i2cbe_pkg::OP_START:i2cbe_pkg::OP_NACK]}) begin
         class_item.is_cmd = 1'b1;
         class_item.op     = req_operation;
      end else begin
         class_item.is_cmd = 1'b0;
         class_item.op     = i2cbe_pkg::OP_TICK;
      end
   end

   i2cbe_fifo #(
      .WIDTH ($bits(i2cbe_pkg::item_type)),
      .DEPTH (DEPTH)
   ) u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (class_item),
      .full      (req_full),
      .pop       (item_pop),
      .pop_data  (item),
      .empty     (item_empty)
   );

   assign item_valid = !item_empty;

endmodule

>>> hw/rtl/i2cbe_engine.sv
// Back end: bus phase sequencer that advances one tick per queued item.
module i2cbe_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic                           csr_index,
   input  logic [i2cbe_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  logic                           item_valid,
   input  i2cbe_pkg::item_type            item,
   output logic                           item_pop,
   input  logic                           rsp_full,
   output logic                           rsp_push,
   output i2cbe_pkg::rsp_type             rsp
);

   logic [15:0] phase_ticks_ff;
   logic [7:0]  ack_poll_limit_ff;

   logic [2:0]  cmd_ff, cmd_in;
   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] tick_ff, tick_in;
   logic [7:0]  poll_ff, poll_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        sda_en_ff, sda_en_in;
   logic        ack_ff, ack_in;
   logic [7:0]  read_ff, read_in;

   logic        fire;
   logic        done;
   logic        enter;
   logic [2:0]  enter_step;
   logic [15:0] eff_ticks;
   logic [7:0]  eff_limit;

   assign fire     = item_valid && !rsp_full;
   assign item_pop = fire;
   assign rsp_push = fire;

   assign eff_ticks = (phase_ticks_ff == '0) ? 16'd1 : phase_ticks_ff;
   assign eff_limit = (ack_poll_limit_ff == '0) ? 8'd1 : ack_poll_limit_ff;

   always_comb begin
      cmd_in     = cmd_ff;
      phase_in   = phase_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      tick_in    = tick_ff;
      poll_in    = poll_ff;
      scl_in     = scl_ff;
      sda_in     = sda_ff;
      sda_en_in  = sda_en_ff;
      ack_in     = ack_ff;
      read_in    = read_ff;
      done       = 1'b0;
      enter      = 1'b0;
      enter_step = 3'd0;

      if (cmd_ff == i2cbe_pkg::OP_TICK) begin
         if (item.is_cmd) begin
            cmd_in  = item.op;
            bit_in  = '0;
            poll_in = '0;
            if (item.op == i2cbe_pkg::OP_WRITE) begin
               shift_in = item.data_byte;
               ack_in   = 1'b0;
            end
            enter = 1'b1;
         end
      end else if (tick_ff > 16'd1) begin
         tick_in = tick_ff - 1'b1;
      end else begin
         case (cmd_ff)
            i2cbe_pkg::OP_START, i2cbe_pkg::OP_ACK, i2cbe_pkg::OP_NACK: begin
               if (phase_ff < 3'd2) begin
                  enter      = 1'b1;
                  enter_step = phase_ff + 1'b1;
               end else begin
                  done = 1'b1;
               end
            end
            i2cbe_pkg::OP_STOP: begin
               if (phase_ff < 3'd1) begin
                  enter      = 1'b1;
                  enter_step = phase_ff + 1'b1;
               end else begin
                  sda_en_in = 1'b0;
                  done      = 1'b1;
               end
            end
            i2cbe_pkg::OP_WRITE: begin
               if (phase_ff == 3'd2) begin
                  bit_in     = bit_ff + 1'b1;
                  enter      = 1'b1;
                  enter_step = (bit_in < 4'd8) ? 3'd0 : 3'd3;
               end else if (phase_ff == 3'd4 || (phase_ff == 3'd5 && poll_ff < eff_limit)) begin
                  phase_in = 3'd5;
                  if (!item.sda_pin) begin
                     ack_in     = 1'b1;
                     enter      = 1'b1;
                     enter_step = 3'd6;
                  end else begin
                     poll_in = poll_ff + 1'b1;
                     tick_in = eff_ticks;
                  end
               end else if (phase_ff == 3'd5) begin
                  enter      = 1'b1;
                  enter_step = 3'd6;
               end else if (phase_ff >= 3'd6) begin
                  sda_en_in = 1'b1;
                  sda_in    = 1'b1;
                  done      = 1'b1;
               end else begin
                  enter      = 1'b1;
                  enter_step = phase_ff + 1'b1;
               end
            end
            i2cbe_pkg::OP_READ: begin
               if (phase_ff < 3'd2) begin
                  enter      = 1'b1;
                  enter_step = phase_ff + 1'b1;
               end else begin
                  bit_in = bit_ff + 1'b1;
                  if (bit_in < 4'd8) begin
                     enter = 1'b1;
                  end else begin
                     read_in = shift_ff;
                     done    = 1'b1;
                  end
               end
            end
            default: begin
               done = 1'b1;
            end
         endcase
      end

      if (done) begin
         cmd_in   = i2cbe_pkg::OP_TICK;
         phase_in = '0;
         tick_in  = '0;
      end

      if (enter) begin
         phase_in = enter_step;
         tick_in  = eff_ticks;
         case (cmd_in)
            i2cbe_pkg::OP_START: begin
               if (enter_step == 3'd0) begin
                  sda_en_in = 1'b1;
                  sda_in    = 1'b1;
                  scl_in    = 1'b1;
               end else if (enter_step == 3'd1) begin
                  sda_in = 1'b0;
               end else begin
                  scl_in = 1'b0;
               end
            end
            i2cbe_pkg::OP_STOP: begin
               if (enter_step == 3'd0) begin
                  sda_en_in = 1'b1;
                  sda_in    = 1'b0;
                  scl_in    = 1'b1;
               end else begin
                  sda_in = 1'b1;
               end
            end
            i2cbe_pkg::OP_ACK, i2cbe_pkg::OP_NACK: begin
               if (enter_step == 3'd0) begin
                  sda_en_in = 1'b1;
                  sda_in    = (cmd_in == i2cbe_pkg::OP_NACK);
               end else if (enter_step == 3'd1) begin
                  scl_in = 1'b1;
               end else begin
                  scl_in = 1'b0;
               end
            end
            i2cbe_pkg::OP_WRITE: begin
               case (enter_step)
                  3'd0: begin
                     sda_en_in = 1'b1;
                     sda_in    = shift_in[7];
                     shift_in  = {shift_in[6:0], 1'b0};
                  end
                  3'd1, 3'd4: scl_in = 1'b1;
                  3'd2, 3'd6: scl_in = 1'b0;
                  3'd3: begin
                     sda_en_in = 1'b0;
                     sda_in    = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
            i2cbe_pkg::OP_READ: begin
               if (enter_step == 3'd0) begin
                  sda_en_in = 1'b0;
               end else if (enter_step == 3'd1) begin
                  scl_in = 1'b1;
               end else begin
                  shift_in = {shift_in[6:0], item.sda_pin};
                  scl_in   = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp.scl_level        = scl_in;
      rsp.sda_drive_enable = sda_en_in;
      rsp.sda_drive_level  = sda_in;
      rsp.busy_res         = (cmd_in != i2cbe_pkg::OP_TICK);
      rsp.done_res         = done;
      rsp.read_byte        = read_in;
      rsp.ack_seen         = ack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff    <= i2cbe_pkg::PHASE_TICKS_RESET;
         ack_poll_limit_ff <= i2cbe_pkg::ACK_POLL_LIMIT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            i2cbe_pkg::CSR_PHASE_TICKS:    phase_ticks_ff    <= csr_write_data;
            i2cbe_pkg::CSR_ACK_POLL_LIMIT: ack_poll_limit_ff <= csr_write_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff    <= i2cbe_pkg::OP_TICK;
         phase_ff  <= '0;
         bit_ff    <= '0;
         shift_ff  <= '0;
         tick_ff   <= '0;
         poll_ff   <= '0;
         scl_ff    <= 1'b1;
         sda_ff    <= 1'b1;
         sda_en_ff <= 1'b0;
         ack_ff    <= 1'b0;
         read_ff   <= '0;
      end else if (fire) begin
         cmd_ff    <= cmd_in;
         phase_ff  <= phase_in;
         bit_ff    <= bit_in;
         shift_ff  <= shift_in;
         tick_ff   <= tick_in;
         poll_ff   <= poll_in;
         scl_ff    <= scl_in;
         sda_ff    <= sda_in;
         sda_en_ff <= sda_en_in;
         ack_ff    <= ack_in;
         read_ff   <= read_in;
      end
   end

endmodule

>>> hw/rtl/i2c_master_bit_engine_unit.sv
// Top level of the I2C master bit engine: one transaction in, one transaction out per tick.
// A tick transaction passes the request queue and then the result queue before its result shows.
// Sustained throughput is one transaction per cycle while the result queue is not full.
// Both queues let either side stall for up to QUEUE_DEPTH transactions without blocking the other.
// Synchronous reset empties both queues, idles the bus (SCL high, SDA released)
// and loads phase_ticks and ack_poll_limit with 50.
module i2c_master_bit_engine_unit #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [2:0]                       req_operation,
   input  logic [7:0]                       req_data_byte,
   input  logic                             req_sda_pin,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic                             rsp_scl_level,
   output logic                             rsp_sda_drive_enable,
   output logic                             rsp_sda_drive_level,
   output logic                             rsp_busy_res,
   output logic                             rsp_done_res,
   output logic [7:0]                       rsp_read_byte,
   output logic                             rsp_ack_seen,
   input  logic                             csr_write_en,
   input  logic                             csr_index,
   input  logic [i2cbe_pkg::CSR_DATA_W-1:0] csr_write_data
);

   i2cbe_pkg::item_type item;
   i2cbe_pkg::rsp_type  rsp_next;
   i2cbe_pkg::rsp_type  rsp_head;
   logic                item_valid;
   logic                item_pop;
   logic                rsp_push;
   logic                rsp_full;

   i2cbe_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_operation (req_operation),
      .req_data_byte (req_data_byte),
      .req_sda_pin   (req_sda_pin),
      .item_valid    (item_valid),
      .item          (item),
      .item_pop      (item_pop)
   );

   i2cbe_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .item_valid     (item_valid),
      .item           (item),
      .item_pop       (item_pop),
      .rsp_full       (rsp_full),
      .rsp_push       (rsp_push),
      .rsp            (rsp_next)
   );

   i2cbe_fifo #(
      .WIDTH ($bits(i2cbe_pkg::rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_next),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_head),
      .empty     (rsp_empty)
   );

   assign rsp_scl_level        = rsp_head.scl_level;
   assign rsp_sda_drive_enable = rsp_head.sda_drive_enable;
   assign rsp_sda_drive_level  = rsp_head.sda_drive_level;
   assign rsp_busy_res         = rsp_head.busy_res;
   assign rsp_done_res         = rsp_head.done_res;
   assign rsp_read_byte        = rsp_head.read_byte;
   assign rsp_ack_seen         = rsp_head.ack_seen;

endmodule

>>> hw/rtl/i2cbe_checker.sv
// Port-level checks of the I2C master bit engine, bound to the top level.
module i2cbe_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic       rsp_scl_level,
   input logic       rsp_sda_drive_enable,
   input logic       rsp_sda_drive_level,
   input logic       rsp_busy_res,
   input logic       rsp_done_res,
   input logic [7:0] rsp_read_byte,
   input logic       rsp_ack_seen
);

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_scl_level)
         && $stable(rsp_sda_drive_enable) && $stable(rsp_sda_drive_level)
         && $stable(rsp_busy_res) && $stable(rsp_done_res)
         && $stable(rsp_read_byte) && $stable(rsp_ack_seen))
      else $error("waiting result changed before it was taken");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_done_res |-> !rsp_busy_res)
      else $error("command completion reported while still busy");

endmodule

bind i2c_master_bit_engine_unit i2cbe_checker u_checker (.*);

>>> bench/i2cbe_bus_checker.sv
// Checker for the I2C master bit engine: predicts every tick and compares each result.
`timescale 1ns / 100ps

module i2cbe_bus_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   input  logic                             req_full,
   input  logic [2:0]                       req_operation,
   input  logic [7:0]                       req_data_byte,
   input  logic                             req_sda_pin,
   input  logic                             rsp_empty,
   input  logic                             rsp_pop,
   input  logic                             rsp_scl_level,
   input  logic                             rsp_sda_drive_enable,
   input  logic                             rsp_sda_drive_level,
   input  logic                             rsp_busy_res,
   input  logic                             rsp_done_res,
   input  logic [7:0]                       rsp_read_byte,
   input  logic                             rsp_ack_seen,
   input  logic                             csr_write_en,
   input  logic                             csr_index,
   input  logic [i2cbe_pkg::CSR_DATA_W-1:0] csr_write_data,
   output int unsigned                      fault_count,
   output int unsigned                      outstanding
);

   logic [15:0] cfg_ticks;
   logic [7:0]  cfg_limit;

   logic [2:0]  cur_cmd;
   logic [2:0]  cur_step;
   logic [3:0]  bit_cnt;
   logic [7:0]  shift_q;
   logic [15:0] tick_cnt;
   logic [7:0]  poll_cnt;
   logic        scl_q;
   logic        sda_q;
   logic        sda_en_q;
   logic        ack_q;
   logic [7:0]  read_q;
   logic        done_q;

   i2cbe_pkg::rsp_type expected_bus_q[$];

   function automatic logic [15:0] phase_len();
      return (cfg_ticks == 16'd0) ? 16'd1 : cfg_ticks;
   endfunction

   function automatic logic [7:0] poll_limit();
      return (cfg_limit == 8'd0) ? 8'd1 : cfg_limit;
   endfunction

   task automatic enter_phase(input logic [2:0] step, input logic pin);
      cur_step = step;
      tick_cnt = phase_len();
      case (cur_cmd)
         i2cbe_pkg::OP_START: begin
            if (step == 3'd0) begin
               sda_en_q = 1'b1;
               sda_q = 1'b1;
               scl_q = 1'b1;
            end else if (step == 3'd1) begin
               sda_q = 1'b0;
            end else begin
               scl_q = 1'b0;
            end
         end
         i2cbe_pkg::OP_STOP: begin
            if (step == 3'd0) begin
               sda_en_q = 1'b1;
               sda_q = 1'b0;
               scl_q = 1'b1;
            end else begin
               sda_q = 1'b1;
            end
         end
         i2cbe_pkg::OP_ACK, i2cbe_pkg::OP_NACK: begin
            if (step == 3'd0) begin
               sda_en_q = 1'b1;
               sda_q = (cur_cmd == i2cbe_pkg::OP_NACK);
            end else if (step == 3'd1) begin
               scl_q = 1'b1;
            end else begin
               scl_q = 1'b0;
            end
         end
         i2cbe_pkg::OP_WRITE: begin
            if (step == 3'd0) begin
               sda_en_q = 1'b1;
               sda_q = shift_q[7];
               shift_q = {shift_q[6:0], 1'b0};
            end else if (step == 3'd1 || step == 3'd4) begin
               scl_q = 1'b1;
            end else if (step == 3'd2 || step == 3'd6) begin
               scl_q = 1'b0;
            end else if (step == 3'd3) begin
               sda_en_q = 1'b0;
               sda_q = 1'b1;
            end
         end
         i2cbe_pkg::OP_READ: begin
            if (step == 3'd0) begin
               sda_en_q = 1'b0;
            end else if (step == 3'd1) begin
               scl_q = 1'b1;
            end else begin
               shift_q = {shift_q[6:0], pin};
               scl_q = 1'b0;
            end
         end
         default: ;
      endcase
   endtask

   task automatic enter_poll(input logic pin);
      cur_step = 3'd5;
      if (!pin) begin
         ack_q = 1'b1;
         enter_phase(3'd6, pin);
      end else begin
         poll_cnt = poll_cnt + 8'd1;
         tick_cnt = phase_len();
      end
   endtask

   task automatic finish_command();
      cur_cmd = i2cbe_pkg::OP_TICK;
      cur_step = 3'd0;
      tick_cnt = 16'd0;
      done_q = 1'b1;
   endtask

   task automatic advance(input logic pin);
      case (cur_cmd)
         i2cbe_pkg::OP_START, i2cbe_pkg::OP_ACK, i2cbe_pkg::OP_NACK: begin
            if (cur_step < 3'd2) enter_phase(cur_step + 3'd1, pin);
            else finish_command();
         end
         i2cbe_pkg::OP_STOP: begin
            if (cur_step < 3'd1) begin
               enter_phase(cur_step + 3'd1, pin);
            end else begin
               sda_en_q = 1'b0;
               finish_command();
            end
         end
         i2cbe_pkg::OP_WRITE: begin
            if (cur_step == 3'd2) begin
               bit_cnt = bit_cnt + 4'd1;
               enter_phase((bit_cnt < 4'd8) ? 3'd0 : 3'd3, pin);
            end else if (cur_step == 3'd4) begin
               enter_poll(pin);
            end else if (cur_step == 3'd5) begin
               if (poll_cnt >= poll_limit()) enter_phase(3'd6, pin);
               else enter_poll(pin);
            end else if (cur_step >= 3'd6) begin
               sda_en_q = 1'b1;
               sda_q = 1'b1;
               finish_command();
            end else begin
               enter_phase(cur_step + 3'd1, pin);
            end
         end
         i2cbe_pkg::OP_READ: begin
            if (cur_step < 3'd2) begin
               enter_phase(cur_step + 3'd1, pin);
            end else begin
               bit_cnt = bit_cnt + 4'd1;
               if (bit_cnt < 4'd8) begin
                  enter_phase(3'd0, pin);
               end else begin
                  read_q = shift_q;
                  finish_command();
               end
            end
         end
         default: finish_command();
      endcase
   endtask

   task automatic predict_bus_tick(input logic [2:0] op, input logic [7:0] data,
                                   input logic pin, output i2cbe_pkg::rsp_type res);
      done_q = 1'b0;
      if (cur_cmd == i2cbe_pkg::OP_TICK) begin
         if (op >= i2cbe_pkg::OP_START && op <= i2cbe_pkg::OP_NACK) begin
            cur_cmd = op;
            bit_cnt = 4'd0;
            poll_cnt = 8'd0;
            if (op == i2cbe_pkg::OP_WRITE) begin
               shift_q = data;
               ack_q = 1'b0;
            end
            enter_phase(3'd0, pin);
         end
      end else if (tick_cnt > 16'd1) begin
         tick_cnt = tick_cnt - 16'd1;
      end else begin
         advance(pin);
      end
      res.scl_level = scl_q;
      res.sda_drive_enable = sda_en_q;
      res.sda_drive_level = sda_q;
      res.busy_res = (cur_cmd != i2cbe_pkg::OP_TICK);
      res.done_res = done_q;
      res.read_byte = read_q;
      res.ack_seen = ack_q;
   endtask

   task automatic check_field(input string name, input logic [7:0] exp_val,
                              input logic [7:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin
      i2cbe_pkg::rsp_type predicted;
      i2cbe_pkg::rsp_type golden;
      if (reset) begin
         cfg_ticks = i2cbe_pkg::PHASE_TICKS_RESET;
         cfg_limit = i2cbe_pkg::ACK_POLL_LIMIT_RESET;
         cur_cmd = i2cbe_pkg::OP_TICK;
         cur_step = 3'd0;
         bit_cnt = 4'd0;
         shift_q = 8'd0;
         tick_cnt = 16'd0;
         poll_cnt = 8'd0;
         scl_q = 1'b1;
         sda_q = 1'b1;
         sda_en_q = 1'b0;
         ack_q = 1'b0;
         read_q = 8'd0;
         done_q = 1'b0;
         expected_bus_q.delete();
      end else begin
         if (csr_write_en) begin
            if (csr_index == i2cbe_pkg::CSR_PHASE_TICKS) cfg_ticks = csr_write_data[15:0];
            else cfg_limit = csr_write_data[7:0];
         end
         if (req_push && !req_full) begin
            predict_bus_tick(req_operation, req_data_byte, req_sda_pin, predicted);
            expected_bus_q.push_back(predicted);
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_bus_q.size() == 0) begin
               $error("result transaction arrived with no expectation waiting");
               fault_count++;
            end else begin
               golden = expected_bus_q.pop_front();
               check_field("scl_level", 8'(golden.scl_level), 8'(rsp_scl_level));
               check_field("sda_drive_enable", 8'(golden.sda_drive_enable),
                           8'(rsp_sda_drive_enable));
               check_field("sda_drive_level", 8'(golden.sda_drive_level),
                           8'(rsp_sda_drive_level));
               check_field("busy_res", 8'(golden.busy_res), 8'(rsp_busy_res));
               check_field("done_res", 8'(golden.done_res), 8'(rsp_done_res));
               check_field("read_byte", golden.read_byte, rsp_read_byte);
               check_field("ack_seen", 8'(golden.ack_seen), 8'(rsp_ack_seen));
            end
         end
      end
      outstanding <= $unsigned(expected_bus_q.size());
   end

endmodule

>>> bench/tb_top.sv
// Top of the I2C master bit engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

   localparam logic [2:0]  OP_UNUSED      = 3'd7;
   localparam int unsigned HOLD_CYCLES    = 300;
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned SETTLE_CYCLES  = 16;
   localparam int unsigned RANDOM_PHASES  = 3;
   localparam int unsigned PHASE_ITEMS    = 80;

   typedef enum logic [1:0] {PIN_RANDOM, PIN_HIGH, PIN_LOW} pin_mode_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_push = 1'b0;
   logic                             req_full;
   logic [2:0]                       req_operation = i2cbe_pkg::OP_TICK;
   logic [7:0]                       req_data_byte = 8'd0;
   logic                             req_sda_pin = 1'b0;
   logic                             rsp_empty;
   logic                             rsp_pop = 1'b0;
   logic                             rsp_scl_level;
   logic                             rsp_sda_drive_enable;
   logic                             rsp_sda_drive_level;
   logic                             rsp_busy_res;
   logic                             rsp_done_res;
   logic [7:0]                       rsp_read_byte;
   logic                             rsp_ack_seen;
   logic                             csr_write_en = 1'b0;
   logic                             csr_index = i2cbe_pkg::CSR_PHASE_TICKS;
   logic [i2cbe_pkg::CSR_DATA_W-1:0] csr_write_data = '0;

   int unsigned fault_count;
   int unsigned outstanding;
   int unsigned items_sent = 0;
   int unsigned commands_sent = 0;
   int unsigned settings_used = 0;
   int unsigned quiet_cycles = 0;
   bit          draining = 1'b0;
   logic [15:0] cfg_ticks_now = i2cbe_pkg::PHASE_TICKS_RESET;
   logic [7:0]  cfg_limit_now = i2cbe_pkg::ACK_POLL_LIMIT_RESET;

   i2c_master_bit_engine_unit dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_operation(req_operation),
      .req_data_byte(req_data_byte),
      .req_sda_pin(req_sda_pin),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_scl_level(rsp_scl_level),
      .rsp_sda_drive_enable(rsp_sda_drive_enable),
      .rsp_sda_drive_level(rsp_sda_drive_level),
      .rsp_busy_res(rsp_busy_res),
      .rsp_done_res(rsp_done_res),
      .rsp_read_byte(rsp_read_byte),
      .rsp_ack_seen(rsp_ack_seen),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   i2cbe_bus_checker bus_check (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_operation(req_operation),
      .req_data_byte(req_data_byte),
      .req_sda_pin(req_sda_pin),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_scl_level(rsp_scl_level),
      .rsp_sda_drive_enable(rsp_sda_drive_enable),
      .rsp_sda_drive_level(rsp_sda_drive_level),
      .rsp_busy_res(rsp_busy_res),
      .rsp_done_res(rsp_done_res),
      .rsp_read_byte(rsp_read_byte),
      .rsp_ack_seen(rsp_ack_seen),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .fault_count(fault_count),
      .outstanding(outstanding)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int unsigned tick_len();
      return (cfg_ticks_now == 16'd0) ? 1 : cfg_ticks_now;
   endfunction

   function automatic int unsigned poll_phases();
      return (cfg_limit_now == 8'd0) ? 1 : cfg_limit_now;
   endfunction

   function automatic int unsigned phase_count(input logic [2:0] op);
      case (op)
         i2cbe_pkg::OP_START, i2cbe_pkg::OP_ACK, i2cbe_pkg::OP_NACK: return 3;
         i2cbe_pkg::OP_STOP: return 2;
         i2cbe_pkg::OP_READ: return 24;
         i2cbe_pkg::OP_WRITE: return 27 + poll_phases();
         default: return 0;
      endcase
   endfunction

   function automatic logic pick_pin(input pin_mode_type mode);
      case (mode)
         PIN_HIGH: return 1'b1;
         PIN_LOW: return 1'b0;
         default: return 1'($urandom_range(1));
      endcase
   endfunction

   function automatic pin_mode_type random_mode();
      case ($urandom_range(2))
         0: return PIN_RANDOM;
         1: return PIN_HIGH;
         default: return PIN_LOW;
      endcase
   endfunction

   task automatic send_item(input logic [2:0] op, input logic [7:0] data, input logic pin);
      bit steady;
      steady = (items_sent >= 600 && items_sent < 1000);
      while (!steady && $urandom_range(99) < 31) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_operation <= op;
      req_data_byte <= data;
      req_sda_pin <= pin;
      do @(posedge clock); while (req_full);
      items_sent++;
   endtask

   task automatic run_ticks(input int count, input pin_mode_type mode, input bit noisy);
      logic [2:0] op;
      logic [7:0] data;
      if (count > 0) begin
         repeat (count) begin
            op = i2cbe_pkg::OP_TICK;
            if (noisy && $urandom_range(99) < 4) op = 3'($urandom_range(7));
            else if ($urandom_range(15) == 0) op = OP_UNUSED;
            data = 8'($urandom_range(255));
            send_item(op, data, pick_pin(mode));
         end
      end
   endtask

   task automatic issue_command(input logic [2:0] op, input logic [7:0] data,
                                input pin_mode_type mode, input bit noisy);
      int span;
      send_item(op, data, pick_pin(mode));
      commands_sent++;
      span = int'(phase_count(op) * tick_len());
      if (noisy) begin
         span = span + int'($urandom_range(3));
         if ($urandom_range(9) == 0) span = span - 1;
      end
      run_ticks(span, mode, noisy);
   endtask

   // Enough clean ticks for the longest command to finish before a register write.
   task automatic settle_engine();
      run_ticks(int'((27 + poll_phases()) * tick_len() + 4), PIN_RANDOM, 1'b0);
   endtask

   task automatic configure(input logic [15:0] ticks, input logic [7:0] limit);
      logic [7:0] upper;
      draining = 1'b1;
      upper = 8'($urandom_range(255));
      req_push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= i2cbe_pkg::CSR_PHASE_TICKS;
      csr_write_data <= ticks;
      @(posedge clock);
      csr_index <= i2cbe_pkg::CSR_ACK_POLL_LIMIT;
      csr_write_data <= {upper, limit};
      @(posedge clock);
      csr_write_en <= 1'b0;
      cfg_ticks_now = ticks;
      cfg_limit_now = limit;
      settings_used++;
      draining = 1'b0;
   endtask

   task automatic run_transfer();
      int unsigned stages;
      logic [2:0]  op;
      if ($urandom_range(9) == 0) begin
         op = 3'($urandom_range(7));
         issue_command(op, 8'($urandom_range(255)), random_mode(), 1'b1);
      end else begin
         issue_command(i2cbe_pkg::OP_START, 8'($urandom_range(255)), PIN_RANDOM, 1'b1);
         stages = $urandom_range(1, 3);
         repeat (stages) begin
            if ($urandom_range(1)) begin
               issue_command(i2cbe_pkg::OP_WRITE, 8'($urandom_range(255)), random_mode(),
                             1'b1);
            end else begin
               issue_command(i2cbe_pkg::OP_READ, 8'($urandom_range(255)), PIN_RANDOM, 1'b1);
               op = $urandom_range(1) ? i2cbe_pkg::OP_ACK : i2cbe_pkg::OP_NACK;
               issue_command(op, 8'($urandom_range(255)), PIN_RANDOM, 1'b1);
            end
         end
         issue_command(i2cbe_pkg::OP_STOP, 8'($urandom_range(255)), PIN_RANDOM, 1'b1);
      end
   endtask

   // The receiver stalls once for a long stretch while the sender keeps offering.
   initial begin
      int unsigned held;
      held = 0;
      forever begin
         if (held == 0 && items_sent >= 900 && !draining) begin
            held = 1;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_pop <= (items_sent >= 1200 && items_sent < 1700) || ($urandom_range(99) >= 31);
         @(posedge clock);
      end
   end

   initial begin
      logic [15:0] ticks;
      logic [7:0]  limit;
      int unsigned phase_end;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      issue_command(i2cbe_pkg::OP_START, 8'h00, PIN_RANDOM, 1'b0);
      run_ticks(4, PIN_RANDOM, 1'b0);

      configure(16'd0, 8'd0);
      send_item(OP_UNUSED, 8'hFF, 1'b1);
      issue_command(i2cbe_pkg::OP_START, 8'h00, PIN_HIGH, 1'b0);
      issue_command(i2cbe_pkg::OP_WRITE, 8'hFF, PIN_LOW, 1'b0);
      issue_command(i2cbe_pkg::OP_WRITE, 8'h00, PIN_HIGH, 1'b0);
      issue_command(i2cbe_pkg::OP_READ, 8'h00, PIN_HIGH, 1'b0);
      issue_command(i2cbe_pkg::OP_ACK, 8'hFF, PIN_RANDOM, 1'b0);
      issue_command(i2cbe_pkg::OP_READ, 8'hFF, PIN_LOW, 1'b0);
      issue_command(i2cbe_pkg::OP_NACK, 8'h00, PIN_RANDOM, 1'b0);
      send_item(i2cbe_pkg::OP_START, 8'h00, 1'b1);
      send_item(i2cbe_pkg::OP_WRITE, 8'h3C, 1'b0);
      run_ticks(4, PIN_RANDOM, 1'b0);
      issue_command(i2cbe_pkg::OP_STOP, 8'h00, PIN_RANDOM, 1'b0);

      configure(16'd1, 8'd255);
      issue_command(i2cbe_pkg::OP_START, 8'h5A, PIN_RANDOM, 1'b0);
      issue_command(i2cbe_pkg::OP_WRITE, 8'hA5, PIN_HIGH, 1'b0);
      issue_command(i2cbe_pkg::OP_WRITE, 8'h5A, PIN_RANDOM, 1'b0);
      issue_command(i2cbe_pkg::OP_STOP, 8'h00, PIN_RANDOM, 1'b0);

      repeat (RANDOM_PHASES) begin
         case ($urandom_range(9))
            0: ticks = 16'd0;
            1: ticks = 16'd1;
            default: ticks = 16'($urandom_range(2, 4));
         endcase
         case ($urandom_range(9))
            0: limit = 8'd0;
            1: limit = 8'd1;
            default: limit = 8'($urandom_range(2, 6));
         endcase
         configure(ticks, limit);
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) run_transfer();
         settle_engine();
      end

      configure(16'hFFFF, 8'd1);
      send_item(i2cbe_pkg::OP_STOP, 8'hC3, 1'b1);
      commands_sent++;
      run_ticks(2, PIN_RANDOM, 1'b0);

      req_push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d tick transactions carrying %0d bus commands over %0d register settings.",
               items_sent, commands_sent, settings_used);
      $display("Included ack timeouts, reads, commands while busy and a long receiver stall.");
      if (fault_count == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
